// ----- rtl/three_wire_rtc_serial_master_top_macros.svh -----
// Assertion macros shared by the three-wire RTC serial master RTL.
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_TOP_MACROS_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clk outside reset.
`define TWRTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clk outside reset.
`define TWRTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/twrtc_pkg.sv -----
// Types, codes and BCD helpers for the three-wire RTC serial master.
`default_nettype none
package twrtc_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_DATA = 2'd2,
    PH_FIN  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] command_byte;
    logic [7:0] write_value;
    logic       io_sample;
  } in_t;

  typedef struct packed {
    logic       serial_clock;
    logic       serial_data_out;
    logic       data_drive;
    logic       chip_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
  } out_t;

  // Binary to BCD, tens*16+units mod 256. Quotient by 10 via *205 >> 11
  // (exact for all 8-bit inputs).
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  tens_x10;
    logic [3:0]  units;
    prod     = 16'(v) * 16'd205;
    tens     = prod[15:11];
    tens_x10 = {tens[4:0], 3'b000} + {2'b00, tens[4:0], 1'b0};
    units    = 4'(v - tens_x10);
    return {tens[3:0], units};
  endfunction

  // BCD to binary, high*10+low, used as is for non-BCD nibbles.
  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    return {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'b0000, v[3:0]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/three_wire_rtc_serial_master_top.sv -----
// Top level of the three-wire RTC serial master: input register, sequencer, result register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in      | into      | in_valid / in_stall   | in_data  (operation, command, value, io)
//   out     | out of    | out_valid / out_stall | out_data (pins, busy, done, read value)
//
// Each tick transfer is held in the input register, is processed by the sequencer in
// the cycle it leaves, and shows up in the result register the next cycle; one
// transfer per cycle is sustained while the result side does not stall.
// The rate is set by the single sequencer state update per tick.
// Reset (rst, synchronous) empties both registers, returns to idle with all pins low.
// A stalled result holds; the input register then fills and in_stall rises.
`default_nettype none
module three_wire_rtc_serial_master_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire twrtc_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output twrtc_pkg::out_t      out_data
);
  import twrtc_pkg::*;

  in_t  held_item;
  logic held_valid;
  out_t result;
  logic advance;

  // the sequencer consumes the held tick whenever the result slot is free or draining
  assign advance  = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_item <= in_data;
    end
  end

  twrtc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (held_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/twrtc_core.sv -----
// Bus sequencer: state registers and per-tick pin/result logic.
`default_nettype none
`include "three_wire_rtc_serial_master_top_macros.svh"
module twrtc_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire twrtc_pkg::in_t  item,
  output twrtc_pkg::out_t      result
);
  import twrtc_pkg::*;

  phase_t               phase, phase_next;
  logic [BIT_IDX_W-1:0] bit_count, bit_count_next;
  logic                 half_step, half_step_next;
  logic                 is_read, is_read_next;
  logic [7:0]           command_shift, command_shift_next;
  logic [7:0]           data_shift, data_shift_next;
  logic [7:0]           received_bits, received_bits_next;
  logic                 pin_clk, pin_clk_next;
  logic                 pin_dat, pin_dat_next;
  logic                 pin_drv, pin_drv_next;
  logic                 pin_ce, pin_ce_next;

  logic start;
  logic last_bit;

  assign start    = (item.operation == OP_READ) || (item.operation == OP_WRITE);
  assign last_bit = half_step && (bit_count == LAST_BIT);

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: if (start) phase_next = PH_CMD;
      PH_CMD:  if (last_bit) phase_next = PH_DATA;
      PH_DATA: if (last_bit) phase_next = PH_FIN;
      PH_FIN:  phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  // datapath and pins
  always_comb begin
    bit_count_next     = bit_count;
    half_step_next     = half_step;
    is_read_next       = is_read;
    command_shift_next = command_shift;
    data_shift_next    = data_shift;
    received_bits_next = received_bits;
    pin_clk_next       = pin_clk;
    pin_dat_next       = pin_dat;
    pin_drv_next       = pin_drv;
    pin_ce_next        = pin_ce;
    unique case (phase)
      PH_IDLE: begin
        if (start) begin
          is_read_next       = (item.operation == OP_READ);
          command_shift_next = (item.operation == OP_READ) ?
                               (item.command_byte | 8'h01) : item.command_byte;
          data_shift_next    = to_bcd(item.write_value);
          received_bits_next = '0;
          bit_count_next     = '0;
          half_step_next     = 1'b0;
          pin_ce_next        = 1'b1;
          pin_drv_next       = 1'b1;
          pin_dat_next       = 1'b0;
          pin_clk_next       = 1'b0;
        end
      end
      PH_CMD: begin
        if (!half_step) begin
          pin_ce_next    = 1'b1;
          pin_drv_next   = 1'b1;
          pin_dat_next   = command_shift[0];
          pin_clk_next   = !is_read;
          half_step_next = 1'b1;
        end else begin
          pin_clk_next       = is_read;
          command_shift_next = {1'b0, command_shift[7:1]};
          half_step_next     = 1'b0;
          bit_count_next     = bit_count + 1'b1;
        end
      end
      PH_DATA: begin
        if (!half_step) begin
          pin_ce_next    = 1'b1;
          pin_clk_next   = 1'b1;
          pin_drv_next   = !is_read;
          pin_dat_next   = !is_read && data_shift[0];
          half_step_next = 1'b1;
        end else begin
          pin_clk_next   = 1'b0;
          half_step_next = 1'b0;
          bit_count_next = bit_count + 1'b1;
          if (is_read) begin
            pin_ce_next        = 1'b1;
            pin_drv_next       = 1'b0;
            pin_dat_next       = 1'b0;
            received_bits_next = {item.io_sample, received_bits[7:1]};
          end else begin
            data_shift_next = {1'b0, data_shift[7:1]};
          end
        end
      end
      PH_FIN: begin
        pin_clk_next   = 1'b0;
        pin_dat_next   = 1'b0;
        pin_drv_next   = 1'b0;
        pin_ce_next    = 1'b0;
        half_step_next = 1'b0;
        bit_count_next = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    result.serial_clock    = pin_clk_next;
    result.serial_data_out = pin_dat_next;
    result.data_drive      = pin_drv_next;
    result.chip_enable     = pin_ce_next;
    result.busy_res        = (phase_next != PH_IDLE);
    result.done_res        = (phase == PH_FIN);
    result.read_value      = (phase == PH_FIN && is_read) ? from_bcd(received_bits) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= '0;
      half_step     <= 1'b0;
      is_read       <= 1'b0;
      command_shift <= '0;
      data_shift    <= '0;
      received_bits <= '0;
      pin_clk       <= 1'b0;
      pin_dat       <= 1'b0;
      pin_drv       <= 1'b0;
      pin_ce        <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      half_step     <= half_step_next;
      is_read       <= is_read_next;
      command_shift <= command_shift_next;
      data_shift    <= data_shift_next;
      received_bits <= received_bits_next;
      pin_clk       <= pin_clk_next;
      pin_dat       <= pin_dat_next;
      pin_drv       <= pin_drv_next;
      pin_ce        <= pin_ce_next;
    end
  end

  `TWRTC_ASSERT_NOW(a_idle_pins_low, phase == PH_IDLE, !pin_ce && !pin_clk && !pin_drv && !pin_dat, "pins not low in idle")
  `TWRTC_ASSERT_NOW(a_busy_ce_high, phase != PH_IDLE, pin_ce, "chip enable low during transaction")
  `TWRTC_ASSERT_NEXT(a_fin_to_idle, step && phase == PH_FIN, phase == PH_IDLE, "finish tick did not return to idle")
  `TWRTC_ASSERT_NEXT(a_hold_when_idle_step, !step, $stable(phase) && $stable(bit_count), "state moved without a tick")

endmodule
`default_nettype wire

// ----- verif/tb_three_wire_rtc_serial_master_top.sv -----
// Testbench for the three-wire RTC serial master: tick stream, pin predictor, scoreboard.
module tb_three_wire_rtc_serial_master_top;
  import twrtc_pkg::*;

  // Operation code three has no name in the package; the block treats it as a plain tick.
  localparam logic [1:0] OP_NONE = 2'd3;

  // One bus transfer: start tick, 8 command bits and 8 data bits at two ticks each,
  // then the finish tick. Data bit i uses ticks DATA_FIRST+2i and DATA_FIRST+2i+1;
  // the second of the two is where a read samples the line.
  localparam int TICKS_PER_TRANSFER = 34;
  localparam int DATA_FIRST         = 17;
  localparam int HOLD_CYCLES        = 60;
  localparam int RANDOM_TICKS       = 600;

  // Pin-level scoreboard. note_tick advances a private copy of the sequencer for each
  // accepted tick and queues the pins it should produce; check_pins compares each
  // accepted result against the oldest queued entry.
  class rtc_pin_scoreboard;
    phase_t     phase;
    logic [2:0] bit_idx;
    logic       half;
    logic       rd;
    logic [7:0] cmd_sr;
    logic [7:0] dat_sr;
    logic [7:0] rx_sr;
    logic       clk_pin, dat_pin, drv_pin, ce_pin;
    out_t       expected_pins[$];
    int         errors, ticks, checked, reads_done, writes_done, ignored_requests;

    function new();
      phase   = PH_IDLE;
      bit_idx = '0;
      half    = 1'b0;
      rd      = 1'b0;
      cmd_sr  = '0;
      dat_sr  = '0;
      rx_sr   = '0;
      clk_pin = 1'b0;
      dat_pin = 1'b0;
      drv_pin = 1'b0;
      ce_pin  = 1'b0;
    endfunction

    function logic [7:0] bcd_of(logic [7:0] v);
      int unsigned n;
      n = v;
      return 8'((n / 10) * 16 + n % 10);
    endfunction

    function logic [7:0] bin_of(logic [7:0] v);
      int unsigned hi, lo;
      hi = v[7:4];
      lo = v[3:0];
      return 8'(hi * 10 + lo);
    endfunction

    // Step to the next bit; true once the whole byte has gone.
    function bit next_bit();
      bit last;
      last    = (bit_idx == 3'd7);
      half    = 1'b0;
      bit_idx = bit_idx + 3'd1;
      return last;
    endfunction

    function int pending();
      return expected_pins.size();
    endfunction

    function void note_tick(in_t t);
      out_t e;
      bit   req;
      e   = '0;
      req = (t.operation == OP_READ) || (t.operation == OP_WRITE);
      ticks++;
      if (phase != PH_IDLE && req) ignored_requests++;
      case (phase)
        PH_IDLE: begin
          if (req) begin
            rd      = (t.operation == OP_READ);
            cmd_sr  = rd ? (t.command_byte | 8'h01) : t.command_byte;
            dat_sr  = bcd_of(t.write_value);
            rx_sr   = '0;
            bit_idx = '0;
            half    = 1'b0;
            phase   = PH_CMD;
            ce_pin  = 1'b1;
            drv_pin = 1'b1;
            clk_pin = 1'b0;
            dat_pin = 1'b0;
          end
        end
        PH_CMD: begin
          if (!half) begin
            ce_pin  = 1'b1;
            drv_pin = 1'b1;
            dat_pin = cmd_sr[0];
            clk_pin = !rd;
            half    = 1'b1;
          end else begin
            clk_pin = rd;
            cmd_sr  = cmd_sr >> 1;
            if (next_bit()) phase = PH_DATA;
          end
        end
        PH_DATA: begin
          if (rd) begin
            ce_pin  = 1'b1;
            drv_pin = 1'b0;
            dat_pin = 1'b0;
            if (!half) begin
              clk_pin = 1'b1;
              half    = 1'b1;
            end else begin
              clk_pin = 1'b0;
              rx_sr   = {t.io_sample, rx_sr[7:1]};
              if (next_bit()) phase = PH_FIN;
            end
          end else if (!half) begin
            ce_pin  = 1'b1;
            drv_pin = 1'b1;
            clk_pin = 1'b1;
            dat_pin = dat_sr[0];
            half    = 1'b1;
          end else begin
            clk_pin = 1'b0;
            dat_sr  = dat_sr >> 1;
            if (next_bit()) phase = PH_FIN;
          end
        end
        default: begin
          ce_pin     = 1'b0;
          drv_pin    = 1'b0;
          clk_pin    = 1'b0;
          dat_pin    = 1'b0;
          e.done_res = 1'b1;
          if (rd) begin
            e.read_value = bin_of(rx_sr);
            reads_done++;
          end else begin
            writes_done++;
          end
          phase   = PH_IDLE;
          half    = 1'b0;
          bit_idx = '0;
        end
      endcase
      e.serial_clock    = clk_pin;
      e.serial_data_out = dat_pin;
      e.data_drive      = drv_pin;
      e.chip_enable     = ce_pin;
      e.busy_res        = (phase != PH_IDLE);
      expected_pins.push_back(e);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pins(out_t got);
      out_t e;
      if (expected_pins.size() == 0) begin
        $error("result transfer with nothing pending: %h", got);
        errors++;
        return;
      end
      e = expected_pins.pop_front();
      checked++;
      compare_field("serial_clock", e.serial_clock, got.serial_clock);
      compare_field("serial_data_out", e.serial_data_out, got.serial_data_out);
      compare_field("data_drive", e.data_drive, got.data_drive);
      compare_field("chip_enable", e.chip_enable, got.chip_enable);
      compare_field("busy_res", e.busy_res, got.busy_res);
      compare_field("done_res", e.done_res, got.done_res);
      compare_field("read_value", e.read_value, got.read_value);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  rtc_pin_scoreboard sb = new();
  bit hold_rx;       // set by the sender to ask the receiver for one long hold-off
  int long_holds;
  int ticks_sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  three_wire_rtc_serial_master_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Both channels are sampled at the falling edge: everything is driven or updated
  // at the rising edge, so what is seen here is exactly what the next rising edge
  // will take as a transfer.
  always @(negedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_tick(in_data);
    if (!rst && out_valid && !out_stall) sb.check_pins(out_data);
  end

  // Gap before a tick: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // Offer one tick and return at the rising edge that takes it, valid still high.
  task automatic send_item(input in_t item, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    ticks_sent++;
  endtask

  // Drop valid and hold off until every queued result has come back.
  // Only called right after send_item, so valid sees one assignment per edge.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Ticks while idle: plain ticks and code three, with arbitrary payload bits.
  task automatic send_idle(input int n);
    in_t item;
    repeat (n) begin
      item.operation    = $urandom_range(0, 1) ? OP_TICK : OP_NONE;
      item.command_byte = $urandom;
      item.write_value  = $urandom;
      item.io_sample    = $urandom;
      send_item(item, pick_gap());
    end
  endtask

  // One whole bus transfer. rx is what the device puts on the line for a read,
  // bit i held through both ticks of data bit i. With noisy set, some ticks carry
  // requests or code three while busy, which the block must ignore. calm drops all gaps.
  task automatic run_transfer(input logic [1:0] op, input logic [7:0] cmd,
                              input logic [7:0] val, input logic [7:0] rx,
                              input bit noisy, input bit calm);
    in_t item;
    for (int k = 0; k < TICKS_PER_TRANSFER; k++) begin
      item.operation    = OP_TICK;
      item.command_byte = $urandom;
      item.write_value  = $urandom;
      item.io_sample    = $urandom;
      if (k == 0) begin
        item.operation    = op;
        item.command_byte = cmd;
        item.write_value  = val;
      end else if (noisy && $urandom_range(0, 4) == 0) begin
        item.operation = $urandom_range(1, 3);
      end
      if (k >= DATA_FIRST && k < DATA_FIRST + 16) item.io_sample = rx[(k - DATA_FIRST) / 2];
      send_item(item, calm ? 0 : pick_gap());
    end
  endtask

  // Receiver: runs of stall and no-stall of random length, calm stretches,
  // and one long hold-off on request so the input side backs up.
  initial begin
    int len;
    bit v;
    int r;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        v       = 1'b1;
        len     = HOLD_CYCLES;
        hold_rx = 1'b0;
        long_holds++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          v   = 1'b0;
          len = $urandom_range(50, 150);
        end else if (r < 55) begin
          v   = 1'b0;
          len = $urandom_range(1, 3);
        end else if (r < 90) begin
          v   = 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          v   = 1'b1;
          len = $urandom_range(5, 30);
        end
      end
      out_stall <= v;
      repeat (len) @(posedge clk);
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    in_t item;
    int  n;
    logic [1:0] op;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Idle ticks must leave the pins alone, whatever the payload says.
    item = '1;
    item.operation = OP_NONE;
    send_item(item, 1);
    item = '0;
    send_item(item, 0);

    // Writes: value zero, top BCD value with busy requests mixed in, and a value
    // above 99 whose BCD form wraps.
    run_transfer(OP_WRITE, 8'h80, 8'd0, 8'h00, 1'b0, 1'b1);
    run_transfer(OP_WRITE, 8'hFF, 8'd99, 8'hFF, 1'b1, 1'b0);
    run_transfer(OP_WRITE, 8'h00, 8'd255, 8'hAA, 1'b0, 1'b0);
    // Reads: command bit 0 forced high, all-ones byte (not BCD, converts to 165),
    // and an ordinary BCD byte.
    run_transfer(OP_READ, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1);
    run_transfer(OP_READ, 8'hFE, 8'h00, 8'hFF, 1'b1, 1'b0);
    run_transfer(OP_READ, 8'hC1, 8'h5A, 8'h59, 1'b0, 1'b0);

    // Random part: mostly full transfers with random content, some idle noise between.
    n = 0;
    while (ticks_sent < RANDOM_TICKS) begin
      send_idle($urandom_range(0, 3));
      op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
      if (n == 8) begin
        // Receiver holds off while ticks keep coming back to back, then the
        // sender waits until everything is back. Valid stays low until the
        // hold-off has begun.
        hold_rx = 1'b1;
        in_valid <= 1'b0;
        wait (hold_rx == 1'b0);
        run_transfer(op, $urandom, $urandom, $urandom, 1'b0, 1'b1);
        drain_results();
      end else begin
        run_transfer(op, $urandom, $urandom, $urandom,
                     $urandom_range(0, 1), $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) drain_results();
      end
      n++;
    end

    // Pick up the tail: valid low, all results home, then a few more cycles for
    // anything unexpected to show.
    drain_results();
    repeat (8) @(posedge clk);

    $display("Ran %0d ticks, %0d results checked, %0d long receiver hold-offs",
             sb.ticks, sb.checked, long_holds);
    $display("Bus transfers finished: %0d reads, %0d writes; %0d requests while busy",
             sb.reads_done, sb.writes_done, sb.ignored_requests);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
